FILE: rtl/core/usan_pkg.sv
// ----------------------------------------------------------------------------
// usan_pkg
// Shared types and constants for the utf-8 byte sanitizer blocks.
// ----------------------------------------------------------------------------
package usan_pkg;

    // replacement character '?'
    localparam logic [7:0] QMARK     = 8'h3F;

    // byte class tags, compared against the top bits of a byte
    localparam logic [1:0] CONT_TAG  = 2'b10;
    localparam logic [2:0] LEAD2_TAG = 3'b110;
    localparam logic [3:0] LEAD3_TAG = 4'b1110;
    localparam logic [4:0] LEAD4_TAG = 5'b11110;

    // sequence lengths opened by each lead class
    localparam logic [2:0] LEN2      = 3'd2;
    localparam logic [2:0] LEN3      = 3'd3;
    localparam logic [2:0] LEN4      = 3'd4;

    // most bytes a single input transaction can produce
    localparam int unsigned MAX_RESULTS = 4;

    // default depth of the queue between front and back
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    // work item handed from front to back: bytes to emit, in order
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [1:0]                  last_idx;
        logic                        eot;
    } bundle_t;

endpackage

FILE: rtl/core/usan_front.sv
// ----------------------------------------------------------------------------
// usan_front
// Accepts input bytes, tracks the open multi-byte sequence and builds the
// list of output bytes that each transaction produces.
// ----------------------------------------------------------------------------
module usan_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        byte_in,
    input  logic              end_of_text,
    input  logic              q_full,
    output logic              push,
    output usan_pkg::bundle_t push_data
);
    import usan_pkg::*;

    logic [7:0] held_reg [0:2];
    logic [1:0] held_count_reg;
    logic [1:0] held_count_next;
    logic [2:0] expected_length_reg;
    logic [2:0] expected_length_next;

    logic       held_wr_en;
    logic [1:0] held_wr_idx;

    logic       in_acc;
    logic       seq_open;
    logic       is_cont;
    logic       is_ascii;
    logic       is_lead2;
    logic       is_lead3;
    logic       is_lead4;
    logic       fresh_open;
    logic       fresh_emit;
    logic [2:0] fresh_len;
    logic [7:0] fresh_byte;
    logic [2:0] held_cnt_ext;
    logic [2:0] next_count;
    logic       seq_done;
    logic [2:0] res_cnt;
    logic [MAX_RESULTS-1:0][7:0] slots;

    assign in_stall = q_full;
    assign in_acc   = in_valid && !q_full;

    // byte classification
    assign is_cont    = (byte_in[7:6] == CONT_TAG);
    assign is_ascii   = !byte_in[7];
    assign is_lead2   = (byte_in[7:5] == LEAD2_TAG);
    assign is_lead3   = (byte_in[7:4] == LEAD3_TAG);
    assign is_lead4   = (byte_in[7:3] == LEAD4_TAG);
    assign fresh_open = is_lead2 || is_lead3 || is_lead4;
    assign fresh_emit = !fresh_open;
    assign fresh_byte = is_ascii ? byte_in : QMARK;
    assign fresh_len  = is_lead2 ? LEN2 : (is_lead3 ? LEN3 : LEN4);

    assign seq_open     = (held_count_reg != 2'd0);
    assign held_cnt_ext = {1'b0, held_count_reg};
    assign next_count   = held_cnt_ext + 3'd1;
    assign seq_done     = (next_count >= expected_length_reg);

    // result list and next sequence state
    always_comb
    begin
        held_count_next      = held_count_reg;
        expected_length_next = expected_length_reg;
        held_wr_en           = 1'b0;
        held_wr_idx          = held_count_reg;
        res_cnt              = 3'd0;
        slots                = '0;
        if (seq_open && is_cont)
        begin
            if (seq_done)
            begin
                // sequence complete: emit held bytes then this one
                slots[0]             = (held_count_reg > 2'd0) ? held_reg[0] : byte_in;
                slots[1]             = (held_count_reg > 2'd1) ? held_reg[1] : byte_in;
                slots[2]             = (held_count_reg > 2'd2) ? held_reg[2] : byte_in;
                slots[3]             = byte_in;
                res_cnt              = next_count;
                held_count_next      = 2'd0;
                expected_length_next = 3'd0;
            end
            else
            begin
                held_wr_en      = 1'b1;
                held_count_next = held_count_reg + 2'd1;
                if (end_of_text)
                begin
                    // unfinished at end of text
                    for (int k = 0; k < MAX_RESULTS; k++)
                    begin
                        slots[k] = QMARK;
                    end
                    res_cnt              = next_count;
                    held_count_next      = 2'd0;
                    expected_length_next = 3'd0;
                end
            end
        end
        else
        begin
            // broken sequence flushes as '?', then the byte is handled fresh
            for (int k = 0; k < MAX_RESULTS; k++)
            begin
                slots[k] = (3'(k) < held_cnt_ext || fresh_open) ? QMARK : fresh_byte;
            end
            res_cnt = held_cnt_ext + {2'b00, fresh_emit || (fresh_open && end_of_text)};
            if (fresh_open && !end_of_text)
            begin
                held_wr_en           = 1'b1;
                held_wr_idx          = 2'd0;
                held_count_next      = 2'd1;
                expected_length_next = fresh_len;
            end
            else
            begin
                held_count_next      = 2'd0;
                expected_length_next = 3'd0;
            end
        end
    end

    assign push               = in_acc && (res_cnt != 3'd0);
    assign push_data.bytes    = slots;
    assign push_data.last_idx = 2'(res_cnt - 3'd1);
    assign push_data.eot      = end_of_text;

    // sequence control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg      <= 2'd0;
            expected_length_reg <= 3'd0;
        end
        else if (in_acc)
        begin
            held_count_reg      <= held_count_next;
            expected_length_reg <= expected_length_next;
        end
    end

    // held sequence bytes
    always_ff @(posedge clk)
    begin
        if (in_acc && held_wr_en)
        begin
            held_reg[held_wr_idx] <= byte_in;
        end
    end

endmodule

FILE: rtl/core/usan_queue.sv
// ----------------------------------------------------------------------------
// usan_queue
// Small fifo of work bundles between the front and the back.
// ----------------------------------------------------------------------------
module usan_queue #(
    parameter int unsigned DEPTH = usan_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  usan_pkg::bundle_t          push_data,
    input  logic                       pop,
    output usan_pkg::bundle_t          head_data,
    output logic                       empty,
    output logic                       full,
    output logic [$clog2(DEPTH+1)-1:0] level
);
    import usan_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned LW = $clog2(DEPTH+1);

    bundle_t         store_reg [0:DEPTH-1];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [LW-1:0]   level_reg;
    logic [LW-1:0]   level_next;
    logic            do_push;
    logic            do_pop;

    assign empty     = (level_reg == LW'(0));
    assign full      = (level_reg == LW'(DEPTH));
    assign level     = level_reg;
    assign head_data = store_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;

    // pointer and level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH-1)) ? PW'(0) : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH-1)) ? PW'(0) : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            level_next = level_reg + LW'(1);
        end
        else if (do_pop && !do_push)
        begin
            level_next = level_reg - LW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/core/usan_back.sv
// ----------------------------------------------------------------------------
// usan_back
// Walks the head bundle one byte per cycle, while the output is not stalled,
// into the output register and pops the bundle after its last byte.
// ----------------------------------------------------------------------------
module usan_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  usan_pkg::bundle_t head_data,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        byte_out,
    output logic              run_last,
    output logic              text_last
);
    import usan_pkg::*;

    logic       out_valid_reg;
    logic [7:0] byte_out_reg;
    logic       run_last_reg;
    logic       text_last_reg;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       out_adv;
    logic       load;
    logic       at_last;

    assign out_adv = !out_valid_reg || !out_stall;
    assign load    = out_adv && head_valid;
    assign at_last = (idx_reg == head_data.last_idx);
    assign pop     = load && at_last;

    // byte index within the head bundle
    always_comb
    begin
        idx_next = idx_reg;
        if (load)
        begin
            idx_next = at_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (out_adv)
            begin
                out_valid_reg <= head_valid;
            end
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_out_reg  <= head_data.bytes[idx_reg];
            run_last_reg  <= at_last;
            text_last_reg <= at_last && head_data.eot;
        end
    end

    assign out_valid = out_valid_reg;
    assign byte_out  = byte_out_reg;
    assign run_last  = run_last_reg;
    assign text_last = text_last_reg;

endmodule

FILE: rtl/core/utf8_byte_sanitizer_top.sv
// ----------------------------------------------------------------------------
// utf8_byte_sanitizer_top
// Repairs a utf-8 byte stream: complete sequences pass, broken or stray
// bytes are replaced by '?'.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one text byte per transaction
//   in byte_in, with end_of_text set on the final byte of a text.
//   Output channel (out_valid / out_stall) carries one byte per transaction;
//   run_last marks the last byte caused by an input byte, text_last the last
//   byte of the text. An input byte yields zero to four output bytes.
//   Output bytes pass through the bundle queue, then the output register.
//   The front takes one input byte per cycle while the queue is not full,
//   the back end one output byte per cycle while out_stall is low; a
//   transaction with several output bytes holds the back end until all are
//   sent, and the bundle queue (QUEUE_DEPTH entries) absorbs the difference.
//   in_stall rises only while the bundle queue is full.
//   Reset clears the open sequence, the queue and the output valid flag.
//   While out_stall is high the output holds; the front keeps accepting until
//   the queue fills.
// ----------------------------------------------------------------------------
module utf8_byte_sanitizer_top #(
    parameter int unsigned QUEUE_DEPTH = usan_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] byte_in,
    input  logic       end_of_text,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] byte_out,
    output logic       run_last,
    output logic       text_last
);
    import usan_pkg::*;

    localparam int unsigned LW = $clog2(QUEUE_DEPTH+1);

    logic          push;
    bundle_t       push_data;
    logic          pop;
    bundle_t       head_data;
    logic          q_empty;
    logic          q_full;
    logic [LW-1:0] q_level;

    // classify and build bundles
    usan_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .byte_in     (byte_in),
        .end_of_text (end_of_text),
        .q_full      (q_full),
        .push        (push),
        .push_data   (push_data)
    );

    // decoupling queue
    usan_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head_data (head_data),
        .empty     (q_empty),
        .full      (q_full),
        .level     (q_level)
    );

    // serialize bundles to the output
    usan_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (!q_empty),
        .head_data  (head_data),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .byte_out   (byte_out),
        .run_last   (run_last),
        .text_last  (text_last)
    );

`ifndef SYNTH
    // queue level never exceeds its depth
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_level <= LW'(QUEUE_DEPTH))
        else $error("queue level above depth");

    // the front never pushes into a full queue
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("push while queue full");

    // a text ends only on the last byte of an input transaction
    a_text_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && text_last |-> run_last)
        else $error("text_last without run_last");

    // a pop with nothing pushed lowers the level by one
    a_pop_level: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !push |=> q_level == $past(q_level) - LW'(1))
        else $error("queue level did not follow pop");
`endif

endmodule

FILE: test/tb_utf8_byte_sanitizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_byte_sanitizer_top
// Self-checking bench for the utf-8 byte sanitizer. A directed table covers
// byte classes, completed, broken and unfinished sequences, then random texts
// built mostly from well-formed characters with some noise. Every accepted
// input byte is run through a local sanitizer model; output transactions are
// compared in order against its bytes, or the table's bytes for typed rows.
// ----------------------------------------------------------------------------
module tb_utf8_byte_sanitizer_top;

    import usan_pkg::*;

    localparam int RANDOM_ITEMS = 430;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 10;

    // one output transaction as seen on the port
    typedef struct packed {
        logic [7:0] value;
        logic       run_end;
        logic       text_end;
    } out_byte_t;

    // one directed row; typed bytes are left-aligned, first output in [31:24]
    typedef struct packed {
        logic [7:0]  in_byte;
        logic        eot;
        logic        typed;
        logic [2:0]  typed_n;
        logic [31:0] typed_bytes;
    } stim_row_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] byte_in;
    logic       end_of_text;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] byte_out;
    logic       run_last;
    logic       text_last;

    // sanitizer model state
    logic [7:0] seq_bytes [3];
    logic [1:0] seq_cnt = 2'd0;
    logic [2:0] seq_len = 3'd0;
    logic [7:0] pred_bytes [4];
    int         pred_n;

    out_byte_t  pending_bytes [$];
    stim_row_t  directed_rows [$];
    int         mismatch_count = 0;
    int         cycle_count = 0;
    bit         sender_quiet = 1'b0;
    bit         receiver_quiet = 1'b0;
    bit         long_hold = 1'b0;

    utf8_byte_sanitizer_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .byte_in     (byte_in),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .byte_out    (byte_out),
        .run_last    (run_last),
        .text_last   (text_last)
    );

    // clock
    always #5 clk = ~clk;

    function automatic int idle_cycles(input bit quiet);
        return quiet ? 0 : $urandom_range(0, 13);
    endfunction

    task automatic emit(input logic [7:0] v);
        pred_bytes[pred_n] = v;
        pred_n++;
    endtask

    // append one expected output transaction
    task automatic expect_out(input out_byte_t want);
        pending_bytes = {pending_bytes, want};
    endtask

    // every held byte becomes '?' and the open sequence is dropped
    task automatic drop_open_sequence();
        repeat (seq_cnt) emit(QMARK);
        seq_cnt = 2'd0;
        seq_len = 3'd0;
    endtask

    // byte handled with no sequence open
    task automatic take_fresh(input logic [7:0] b);
        if (b[7] == 1'b0)
        begin
            emit(b);
        end
        else if (b[7:5] == LEAD2_TAG)
        begin
            seq_bytes[0] = b;
            seq_cnt = 2'd1;
            seq_len = LEN2;
        end
        else if (b[7:4] == LEAD3_TAG)
        begin
            seq_bytes[0] = b;
            seq_cnt = 2'd1;
            seq_len = LEN3;
        end
        else if (b[7:3] == LEAD4_TAG)
        begin
            seq_bytes[0] = b;
            seq_cnt = 2'd1;
            seq_len = LEN4;
        end
        else
        begin
            emit(QMARK);
        end
    endtask

    // predicted output bytes for one input byte, left in pred_bytes/pred_n
    task automatic sanitize_byte(input logic [7:0] b, input logic eot);
        pred_n = 0;
        if (seq_cnt != 2'd0)
        begin
            if (b[7:6] == CONT_TAG)
            begin
                if ({1'b0, seq_cnt} + 3'd1 >= seq_len)
                begin
                    for (int k = 0; k < seq_cnt; k++)
                        emit(seq_bytes[k]);
                    emit(b);
                    seq_cnt = 2'd0;
                    seq_len = 3'd0;
                end
                else
                begin
                    seq_bytes[seq_cnt] = b;
                    seq_cnt = seq_cnt + 2'd1;
                end
            end
            else
            begin
                drop_open_sequence();
                take_fresh(b);
            end
        end
        else
        begin
            take_fresh(b);
        end
        // unfinished sequence at end of text
        if (eot)
            drop_open_sequence();
    endtask

    // offer one byte, wait for its transaction, queue what it must produce
    task automatic drive_byte(input logic [7:0] b, input logic eot, input logic typed,
                              input logic [2:0] typed_n, input logic [31:0] typed_bytes);
        int        gap;
        out_byte_t want;
        gap = idle_cycles(sender_quiet);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        byte_in     <= b;
        end_of_text <= eot;
        do @(posedge clk); while (in_stall);
        sanitize_byte(b, eot);
        if (typed)
        begin
            for (int i = 0; i < typed_n; i++)
            begin
                want.value    = typed_bytes[31 - 8 * i -: 8];
                want.run_end  = (i == typed_n - 1);
                want.text_end = eot && (i == typed_n - 1);
                expect_out(want);
            end
        end
        else
        begin
            for (int i = 0; i < pred_n; i++)
            begin
                want.value    = pred_bytes[i];
                want.run_end  = (i == pred_n - 1);
                want.text_end = eot && (i == pred_n - 1);
                expect_out(want);
            end
        end
        @(negedge clk);
    endtask

    task automatic table_row(input logic [7:0] b, input logic eot, input logic typed,
                             input logic [2:0] typed_n, input logic [31:0] typed_bytes);
        stim_row_t row;
        row.in_byte     = b;
        row.eot         = eot;
        row.typed       = typed;
        row.typed_n     = typed_n;
        row.typed_bytes = typed_bytes;
        directed_rows   = {directed_rows, row};
    endtask

    // output checking against the oldest expected byte
    always @(posedge clk)
    begin : output_check
        out_byte_t seen;
        out_byte_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            seen.value    = byte_out;
            seen.run_end  = run_last;
            seen.text_end = text_last;
            if (pending_bytes.size() == 0)
            begin
                if (mismatch_count < MAX_REPORTS)
                    $display("unexpected output: byte %h run_last %b text_last %b",
                             seen.value, seen.run_end, seen.text_end);
                mismatch_count++;
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (seen.value !== want.value || seen.run_end !== want.run_end ||
                    seen.text_end !== want.text_end)
                begin
                    if (mismatch_count < MAX_REPORTS)
                        $display("mismatch: expected %h/%b/%b got %h/%b/%b",
                                 want.value, want.run_end, want.text_end,
                                 seen.value, seen.run_end, seen.text_end);
                    mismatch_count++;
                end
            end
        end
    end

    // output side: random stalls, quiet stretches, one long hold-off
    initial
    begin : receiver
        int gap;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (long_hold)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                long_hold = 1'b0;
            end
            gap = idle_cycles(receiver_quiet);
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            if ($urandom_range(0, 15) == 0)
                receiver_quiet = !receiver_quiet;
            @(negedge clk);
        end
    end

    // run limit
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // stimulus and end of run
    initial
    begin : stimulus
        logic [7:0]  text_q [$];
        logic [7:0]  nb;
        logic [31:0] rnd;
        int          sent;
        int          texts;
        int          chunks;
        int          kind;
        int          seq_n;
        int          conts;
        in_valid    = 1'b0;
        byte_in     = 8'h00;
        end_of_text = 1'b0;
        rst_n       = 1'b0;
        sent        = 0;
        texts       = 0;

        // directed table: byte, eot, typed, count, expected bytes
        table_row(8'h41, 1'b0, 1'b1, 3'd1, 32'h4100_0000);  // ascii
        table_row(8'h00, 1'b0, 1'b1, 3'd1, 32'h0000_0000);  // lowest byte
        table_row(8'h7F, 1'b0, 1'b1, 3'd1, 32'h7F00_0000);  // highest ascii
        table_row(8'h80, 1'b0, 1'b1, 3'd1, 32'h3F00_0000);  // stray continuation
        table_row(8'hBF, 1'b0, 1'b1, 3'd1, 32'h3F00_0000);  // stray continuation
        table_row(8'hF8, 1'b0, 1'b1, 3'd1, 32'h3F00_0000);  // invalid lead
        table_row(8'hFF, 1'b0, 1'b1, 3'd1, 32'h3F00_0000);  // invalid lead
        table_row(8'hC0, 1'b0, 1'b1, 3'd0, 32'h0000_0000);  // two-byte lead
        table_row(8'h80, 1'b0, 1'b0, 3'd0, 32'h0000_0000);
        table_row(8'hDF, 1'b0, 1'b1, 3'd0, 32'h0000_0000);
        table_row(8'h41, 1'b0, 1'b1, 3'd2, 32'h3F41_0000);  // broken by ascii
        table_row(8'hE0, 1'b0, 1'b1, 3'd0, 32'h0000_0000);  // three-byte lead
        table_row(8'hA0, 1'b0, 1'b1, 3'd0, 32'h0000_0000);
        table_row(8'hBF, 1'b0, 1'b0, 3'd0, 32'h0000_0000);
        table_row(8'hF7, 1'b0, 1'b1, 3'd0, 32'h0000_0000);  // four-byte lead
        table_row(8'hBF, 1'b0, 1'b0, 3'd0, 32'h0000_0000);
        table_row(8'hBF, 1'b0, 1'b0, 3'd0, 32'h0000_0000);
        table_row(8'hBF, 1'b0, 1'b0, 3'd0, 32'h0000_0000);
        table_row(8'hF0, 1'b0, 1'b1, 3'd0, 32'h0000_0000);
        table_row(8'h90, 1'b0, 1'b1, 3'd0, 32'h0000_0000);
        table_row(8'h80, 1'b0, 1'b1, 3'd0, 32'h0000_0000);
        table_row(8'hEF, 1'b0, 1'b1, 3'd3, 32'h3F3F_3F00);  // broken by a lead
        table_row(8'h80, 1'b1, 1'b1, 3'd2, 32'h3F3F_0000);  // unfinished at end
        table_row(8'hC2, 1'b1, 1'b1, 3'd1, 32'h3F00_0000);  // lead on last byte
        table_row(8'h5A, 1'b1, 1'b1, 3'd1, 32'h5A00_0000);
        table_row(8'hFF, 1'b1, 1'b1, 3'd1, 32'h3F00_0000);
        table_row(8'hD0, 1'b0, 1'b0, 3'd0, 32'h0000_0000);
        table_row(8'h8F, 1'b1, 1'b0, 3'd0, 32'h0000_0000);  // completes at end

        // reset
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part
        foreach (directed_rows[i])
            drive_byte(directed_rows[i].in_byte, directed_rows[i].eot,
                       directed_rows[i].typed, directed_rows[i].typed_n,
                       directed_rows[i].typed_bytes);

        // random texts; the receiver holds off once while the first ones stream
        long_hold = 1'b1;
        while (sent < RANDOM_ITEMS)
        begin
            sender_quiet = (texts < 2) || ($urandom_range(0, 3) == 0);
            text_q.delete();
            chunks = $urandom_range(1, 12);
            for (int c = 0; c < chunks; c++)
            begin
                kind = $urandom_range(0, 99);
                rnd  = $urandom;
                if (kind < 35)
                begin
                    nb     = {1'b0, rnd[6:0]};
                    text_q = {text_q, nb};
                end
                else if (kind < 90)
                begin
                    // well-formed character, or a truncated one
                    seq_n = $urandom_range(2, 4);
                    case (seq_n)
                        2: nb = {LEAD2_TAG, rnd[4:0]};
                        3: nb = {LEAD3_TAG, rnd[3:0]};
                        default: nb = {LEAD4_TAG, rnd[2:0]};
                    endcase
                    text_q = {text_q, nb};
                    conts = (kind < 75) ? seq_n - 1 : $urandom_range(0, seq_n - 2);
                    repeat (conts)
                    begin
                        rnd    = $urandom;
                        nb     = {CONT_TAG, rnd[5:0]};
                        text_q = {text_q, nb};
                    end
                end
                else
                begin
                    nb     = rnd[7:0];
                    text_q = {text_q, nb};
                end
            end
            foreach (text_q[i])
                drive_byte(text_q[i], i == text_q.size() - 1, 1'b0, 3'd0, 32'd0);
            sent += text_q.size();
            texts++;
        end
        in_valid <= 1'b0;

        // drain and verdict
        while (pending_bytes.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_bytes.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
